// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the histogram builder. They compile
// away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: same-cycle implication");
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(lbl, clk, rst, cond, prop)
`define ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif

`endif

// ===== design/chb_pkg.sv =====
// ----------------------------------------------------------------------------
// Color histogram builder package
// Operation codes, pixel thresholds, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package chb_pkg;

  // Operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Pixel qualification thresholds
  localparam logic [7:0] ALPHA_MIN   = 8'd125;
  localparam logic [7:0] WHITE_LEVEL = 8'd250;

  // Reset value of the min trackers
  localparam logic [7:0] MIN_RESET = 8'd255;

  // Controller states
  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted input transaction
    logic sweep_we;  // write zero at the sweep pointer and advance it
    logic update;    // apply the captured item to bins and trackers
    logic clr_trk;   // reset trackers and stride position
    logic load_out;  // load the result register
  } chb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sweep_last;  // sweep pointer sits on the last bin
    logic op_clear;    // captured operation is a clear
  } chb_status_t;

endpackage

`default_nettype wire

// ===== design/chb_if.sv =====
// ----------------------------------------------------------------------------
// Color histogram builder channels
// Valid/ready interfaces for input items, result items and the stride
// register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface chb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [14:0] bin_index;

  modport source (output valid, output operation, output red, output green,
                  output blue, output alpha, output bin_index, input ready);
  modport sink   (input valid, input operation, input red, input green,
                  input blue, input alpha, input bin_index, output ready);
endinterface

interface chb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] bin_count;
  logic [7:0]  min_red;
  logic [7:0]  min_green;
  logic [7:0]  min_blue;
  logic [4:0]  max_red;
  logic [4:0]  max_green;
  logic [4:0]  max_blue;
  logic        any_counted;

  modport source (output valid, output bin_count, output min_red, output min_green,
                  output min_blue, output max_red, output max_green, output max_blue,
                  output any_counted, input ready);
  modport sink   (input valid, input bin_count, input min_red, input min_green,
                  input min_blue, input max_red, input max_green, input max_blue,
                  input any_counted, output ready);
endinterface

interface chb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_stride;

  modport source (output valid, output sample_stride, input ready);
  modport sink   (input valid, input sample_stride, output ready);
endinterface

`default_nettype wire

// ===== design/color_histogram_builder_core.sv =====
// Sequence: a pixel, read or no-op transaction is captured, then passes the read,
//   update and done states before its result is loaded; a clear sweeps all bins.
// Input: a new transaction is taken only after the previous one loads its result,
//   ending the memory read-modify-write sequence of capture, read, update and load.
// Reset: synchronous; a clearing pass over all 2^(3*SIGNIFICANT_BITS) bins (32768
//   at default) zeroes the bins before the first input transaction is accepted.
// ----------------------------------------------------------------------------
// Color histogram builder core
// Top level: joins controller and datapath to the item, result and stride
// register channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module color_histogram_builder_core #(
  parameter int SIGNIFICANT_BITS = 5,
  parameter int COUNT_BITS       = 32
) (
  input  wire        clk,
  input  wire        rst,
  chb_in_if.sink     item,
  chb_out_if.source  result,
  chb_cfg_if.sink    cfg
);
  import chb_pkg::*;

  chb_cmd_t    cmd;
  chb_status_t status;

  // Stride register writes are always taken
  assign cfg.ready = 1'b1;

  chb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .status    (status),
    .cmd       (cmd)
  );

  chb_datapath #(
    .SIGNIFICANT_BITS (SIGNIFICANT_BITS),
    .COUNT_BITS       (COUNT_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg.valid),
    .cfg_data    (cfg.sample_stride),
    .operation   (item.operation),
    .red         (item.red),
    .green       (item.green),
    .blue        (item.blue),
    .alpha       (item.alpha),
    .bin_index   (item.bin_index),
    .bin_count   (result.bin_count),
    .min_red     (result.min_red),
    .min_green   (result.min_green),
    .min_blue    (result.min_blue),
    .max_red     (result.max_red),
    .max_green   (result.max_green),
    .max_blue    (result.max_blue),
    .any_counted (result.any_counted)
  );

  // No input transaction is taken while bins are being swept
  `ASSERT_IMPL(a_no_accept_in_sweep, clk, rst, cmd.sweep_we, !item.ready)
  // A new result is loaded only when the previous one has left
  `ASSERT_IMPL(a_load_slot_free, clk, rst, cmd.load_out, !result.valid || result.ready)
  // One item at a time: after a capture the input side stays closed
  `ASSERT_NEXT(a_single_item, clk, rst, cmd.capture, !item.ready && !cmd.load_out)
  // A loaded result is presented in the next cycle
  `ASSERT_NEXT(a_load_shows_valid, clk, rst, cmd.load_out, result.valid)

endmodule

`default_nettype wire

// ===== design/chb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Color histogram builder controller
// Sequences one transaction at a time: capture, memory read, update or clear
// sweep, then result hand-off. Also runs the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module chb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  out_ready,
  output logic                 out_valid,
  input  chb_pkg::chb_status_t status,
  output chb_pkg::chb_cmd_t    cmd
);
  import chb_pkg::*;

  state_t state;
  state_t state_next;
  logic   slot_free;

  // Result register can take a new result this cycle
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep_we = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_READ: begin
        state_next = status.op_clear ? ST_SWEEP : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_DONE;
      end
      ST_SWEEP: begin
        cmd.sweep_we = 1'b1;
        if (status.sweep_last) begin
          cmd.clr_trk = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // Advance state; hold the result valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/chb_datapath.sv =====
// ----------------------------------------------------------------------------
// Color histogram builder datapath
// Bin memory with sweep pointer, pixel qualification and reduction, stride
// counter, min/max trackers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chb_datapath #(
  parameter int SIGNIFICANT_BITS = 5,
  parameter int COUNT_BITS       = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  chb_pkg::chb_cmd_t    cmd,
  output chb_pkg::chb_status_t status,
  input  wire                  cfg_we,
  input  wire [7:0]            cfg_data,
  input  wire [1:0]            operation,
  input  wire [7:0]            red,
  input  wire [7:0]            green,
  input  wire [7:0]            blue,
  input  wire [7:0]            alpha,
  input  wire [14:0]           bin_index,
  output logic [31:0]          bin_count,
  output logic [7:0]           min_red,
  output logic [7:0]           min_green,
  output logic [7:0]           min_blue,
  output logic [4:0]           max_red,
  output logic [4:0]           max_green,
  output logic [4:0]           max_blue,
  output logic                 any_counted
);
  import chb_pkg::*;

  localparam int SB    = SIGNIFICANT_BITS;
  localparam int DROP  = 8 - SB;
  localparam int IW    = 3 * SB;
  localparam int DEPTH = 1 << IW;
  localparam int EXT_W = (IW > 15) ? IW : 15;

  // Bin memory
  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [IW-1:0]         mem_raddr;

  // Captured item
  op_t         op_q;
  logic [7:0]  chan_q [3];
  logic [7:0]  alpha_q;
  logic [14:0] bin_index_q;

  // Control registers
  logic [IW-1:0] sweep_ptr;
  logic [7:0]    sample_stride;
  logic [7:0]    stride_pos;

  // Trackers
  logic [7:0]    min_q [3];
  logic [SB-1:0] max_q [3];
  logic          found;
  logic [COUNT_BITS-1:0] count_q;

  // Combinational pixel signals
  logic [SB-1:0]    red_v [3];
  logic [IW-1:0]    pix_idx;
  logic [EXT_W-1:0] read_ext;
  logic             white;
  logic             use_pix;
  logic             counted;
  logic [8:0]       stride_eff;
  logic [8:0]       pos_inc;
  logic [COUNT_BITS-1:0] bumped;
  logic [63:0]      count_ext;
  logic [7:0]       max_ext [3];

  // Reduce channels and qualify the captured pixel
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      red_v[c]   = chan_q[c][7:DROP];
      max_ext[c] = 8'(max_q[c]);
    end
    pix_idx    = {red_v[0], red_v[1], red_v[2]};
    read_ext   = EXT_W'(bin_index_q);
    white      = (chan_q[0] > WHITE_LEVEL) && (chan_q[1] > WHITE_LEVEL) &&
                 (chan_q[2] > WHITE_LEVEL);
    use_pix    = (stride_pos == 8'd0);
    counted    = (op_q == OP_PIXEL) && use_pix && (alpha_q >= ALPHA_MIN) && !white;
    stride_eff = (sample_stride == 8'd0) ? 9'd1 : {1'b0, sample_stride};
    pos_inc    = {1'b0, stride_pos} + 9'd1;
    bumped     = (rdata == {COUNT_BITS{1'b1}}) ? rdata : rdata + 1'b1;
    count_ext  = 64'(count_q);
  end

  // Memory address and write selection
  assign mem_raddr = (op_q == OP_PIXEL) ? pix_idx : read_ext[IW-1:0];
  assign mem_we    = cmd.sweep_we || (cmd.update && counted);
  assign mem_waddr = cmd.sweep_we ? sweep_ptr : mem_raddr;
  assign mem_wdata = cmd.sweep_we ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign status.sweep_last = &sweep_ptr;
  assign status.op_clear   = (op_q == OP_CLEAR);

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= op_t'(operation);
      chan_q[0]   <= red;
      chan_q[1]   <= green;
      chan_q[2]   <= blue;
      alpha_q     <= alpha;
      bin_index_q <= bin_index;
    end
  end

  // Sweep pointer, stride register and stride position
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr     <= '0;
      sample_stride <= 8'd1;
      stride_pos    <= 8'd0;
    end else begin
      if (cmd.sweep_we) begin
        sweep_ptr <= sweep_ptr + 1'b1;
      end
      if (cfg_we) begin
        sample_stride <= cfg_data;
      end
      if (cmd.clr_trk) begin
        stride_pos <= 8'd0;
      end else if (cmd.update && (op_q == OP_PIXEL)) begin
        stride_pos <= (pos_inc >= stride_eff) ? 8'd0 : pos_inc[7:0];
      end
    end
  end

  // Min/max trackers and found flag
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_trk) begin
      for (int c = 0; c < 3; c++) begin
        min_q[c] <= MIN_RESET;
        max_q[c] <= '0;
      end
      found <= 1'b0;
    end else if (cmd.update && counted) begin
      for (int c = 0; c < 3; c++) begin
        if (8'(red_v[c]) < min_q[c]) begin
          min_q[c] <= 8'(red_v[c]);
        end
        if (red_v[c] > max_q[c]) begin
          max_q[c] <= red_v[c];
        end
      end
      found <= 1'b1;
    end
  end

  // Latch the bin count for reads; zero otherwise
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      case (op_q)
        OP_READ: count_q <= rdata;
        default: count_q <= '0;
      endcase
    end else if (cmd.clr_trk) begin
      count_q <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      bin_count   <= count_ext[31:0];
      min_red     <= min_q[0];
      min_green   <= min_q[1];
      min_blue    <= min_q[2];
      max_red     <= max_ext[0][4:0];
      max_green   <= max_ext[1][4:0];
      max_blue    <= max_ext[2][4:0];
      any_counted <= found;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_color_histogram_builder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color histogram builder core testbench
// Drives pixel, bin read, clear and no-op transactions into the core and
// scores every result against an in-bench model of the bins, the min/max
// trackers and the stride counter. Directed tests cover the pixel qualifying
// rules, the stride corner cases and clearing. Random traffic follows under
// three sender/receiver stall settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_color_histogram_builder_core;
  import chb_pkg::*;

  localparam int SIG_BITS  = 5;
  localparam int DROP_BITS = 8 - SIG_BITS;

  typedef struct {
    op_t         operation;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] bin_index;
  } hist_item_t;

  typedef struct {
    logic [31:0] bin_count;
    logic [7:0]  min_red;
    logic [7:0]  min_green;
    logic [7:0]  min_blue;
    logic [4:0]  max_red;
    logic [4:0]  max_green;
    logic [4:0]  max_blue;
    logic        any_counted;
  } hist_result_t;

  logic clk;
  logic rst;

  chb_in_if  item_if ();
  chb_out_if result_if ();
  chb_cfg_if stride_if ();

  color_histogram_builder_core DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (stride_if)
  );

  // Model state of the histogram
  bit [31:0]    bin_counts [int];
  bit [7:0]     model_stride;
  bit [7:0]     stride_pos;
  bit [7:0]     chan_min [3];
  bit [4:0]     chan_max [3];
  bit           found_any;
  int           hit_bins [$];
  hist_result_t pending_results [$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  hist_item_t palette [6];

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Overall time limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset the trackers and stride position
  function automatic void reset_trackers();
    for (int c = 0; c < 3; c++) begin
      chan_min[c] = MIN_RESET;
      chan_max[c] = '0;
    end
    found_any  = 1'b0;
    stride_pos = '0;
  endfunction

  // Apply one transaction to the model and return the result it gives
  function automatic hist_result_t histogram_predict(hist_item_t it);
    hist_result_t res;
    bit [7:0]     eff_stride;
    bit [8:0]     next_pos;
    bit           take;
    bit [4:0]     lvl [3];
    bit [14:0]    idx;
    res.bin_count = '0;
    case (it.operation)
      OP_PIXEL: begin
        eff_stride = (model_stride == 0) ? 8'd1 : model_stride;
        take       = (stride_pos == 0);
        next_pos   = stride_pos + 9'd1;
        stride_pos = (next_pos >= eff_stride) ? 8'd0 : next_pos[7:0];
        if (take && it.alpha >= ALPHA_MIN &&
            !(it.red > WHITE_LEVEL && it.green > WHITE_LEVEL && it.blue > WHITE_LEVEL)) begin
          lvl[0] = 5'(it.red >> DROP_BITS);
          lvl[1] = 5'(it.green >> DROP_BITS);
          lvl[2] = 5'(it.blue >> DROP_BITS);
          for (int c = 0; c < 3; c++) begin
            if (lvl[c] > chan_max[c]) chan_max[c] = lvl[c];
            if ({3'b000, lvl[c]} < chan_min[c]) chan_min[c] = {3'b000, lvl[c]};
          end
          idx = {lvl[0], lvl[1], lvl[2]};
          if (!bin_counts.exists(idx)) bin_counts[idx] = '0;
          if (bin_counts[idx] != '1) bin_counts[idx] = bin_counts[idx] + 1;
          found_any = 1'b1;
          if (hit_bins.size() < 64) hit_bins.insert(hit_bins.size(), int'(idx));
        end
      end
      OP_READ: begin
        if (bin_counts.exists(it.bin_index)) res.bin_count = bin_counts[it.bin_index];
      end
      OP_CLEAR: begin
        bin_counts.delete();
        hit_bins.delete();
        reset_trackers();
      end
      default: ;
    endcase
    res.min_red     = chan_min[0];
    res.min_green   = chan_min[1];
    res.min_blue    = chan_min[2];
    res.max_red     = chan_max[0];
    res.max_green   = chan_max[1];
    res.max_blue    = chan_max[2];
    res.any_counted = found_any;
    return res;
  endfunction

  function automatic hist_item_t make_item(op_t op, int r, int g, int b, int a, int bin);
    hist_item_t it;
    it.operation = op;
    it.red       = r[7:0];
    it.green     = g[7:0];
    it.blue      = b[7:0];
    it.alpha     = a[7:0];
    it.bin_index = bin[14:0];
    return it;
  endfunction

  function automatic int bin_of(int r, int g, int b);
    return ((r >> DROP_BITS) << (2 * SIG_BITS)) | ((g >> DROP_BITS) << SIG_BITS) |
           (b >> DROP_BITS);
  endfunction

  // Present one transaction, wait for acceptance, record its expected result
  task automatic send_item(hist_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid     <= 1'b1;
    item_if.operation <= it.operation;
    item_if.red       <= it.red;
    item_if.green     <= it.green;
    item_if.blue      <= it.blue;
    item_if.alpha     <= it.alpha;
    item_if.bin_index <= it.bin_index;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    pending_results.insert(pending_results.size(), histogram_predict(it));
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic drain_results();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the stride register while the core is idle
  task automatic write_stride(int value);
    drain_results();
    @(negedge clk);
    stride_if.valid         <= 1'b1;
    stride_if.sample_stride <= value[7:0];
    do @(posedge clk); while (stride_if.ready !== 1'b1);
    model_stride = value[7:0];
    @(negedge clk);
    stride_if.valid <= 1'b0;
  endtask

  // Drive result ready with random stalls
  always @(negedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Score each accepted result against the oldest expectation
  always @(posedge clk) begin : score_results
    hist_result_t exp_res;
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expected result pending");
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("bin_count",   exp_res.bin_count,   result_if.bin_count);
        check_field("min_red",     32'(exp_res.min_red),     32'(result_if.min_red));
        check_field("min_green",   32'(exp_res.min_green),   32'(result_if.min_green));
        check_field("min_blue",    32'(exp_res.min_blue),    32'(result_if.min_blue));
        check_field("max_red",     32'(exp_res.max_red),     32'(result_if.max_red));
        check_field("max_green",   32'(exp_res.max_green),   32'(result_if.max_green));
        check_field("max_blue",    32'(exp_res.max_blue),    32'(result_if.max_blue));
        check_field("any_counted", 32'(exp_res.any_counted), 32'(result_if.any_counted));
      end
    end
  end

  // Freshly reset core: empty trackers and empty bins at both ends
  task automatic test_reset_state();
    send_item(make_item(OP_NONE, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 255, 255, 255, 255, 32767));
  endtask

  // Alpha and near-white qualifying rules at their thresholds
  task automatic test_pixel_qualify();
    send_item(make_item(OP_PIXEL, 0, 0, 0, 255, 0));
    send_item(make_item(OP_PIXEL, 255, 255, 255, 255, 0));
    send_item(make_item(OP_PIXEL, 251, 251, 251, 200, 0));
    send_item(make_item(OP_PIXEL, 250, 255, 255, 125, 0));
    send_item(make_item(OP_PIXEL, 64, 32, 16, 124, 0));
    send_item(make_item(OP_PIXEL, 255, 0, 128, 200, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, 32767));
    send_item(make_item(OP_READ, 0, 0, 0, 0, bin_of(255, 0, 128)));
  endtask

  // A stride of zero behaves as one
  task automatic test_stride_zero();
    write_stride(0);
    send_item(make_item(OP_PIXEL, 8, 8, 8, 255, 0));
    send_item(make_item(OP_PIXEL, 8, 8, 8, 255, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, bin_of(8, 8, 8)));
  endtask

  // Lower the stride below the current position, then use the extremes
  task automatic test_stride_lowered();
    write_stride(10);
    send_item(make_item(OP_PIXEL, 100, 100, 100, 255, 0));
    send_item(make_item(OP_PIXEL, 200, 16, 40, 255, 0));
    send_item(make_item(OP_PIXEL, 200, 16, 40, 255, 0));
    send_item(make_item(OP_PIXEL, 200, 16, 40, 255, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, bin_of(100, 100, 100)));
    write_stride(2);
    send_item(make_item(OP_PIXEL, 24, 24, 24, 255, 0));
    send_item(make_item(OP_PIXEL, 48, 160, 240, 255, 0));
    write_stride(255);
    send_item(make_item(OP_PIXEL, 48, 160, 240, 255, 0));
    write_stride(5);
    send_item(make_item(OP_PIXEL, 48, 160, 240, 255, 0));
  endtask

  // Clear empties the bins and trackers and restarts the stride count
  task automatic test_clear();
    send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    send_item(make_item(OP_READ, 0, 0, 0, 0, bin_of(48, 160, 240)));
    send_item(make_item(OP_PIXEL, 120, 60, 30, 130, 0));
    send_item(make_item(OP_NONE, 0, 0, 0, 0, 0));
  endtask

  // Build one random transaction, weighted toward counted pixels and hit bins
  function automatic hist_item_t random_item();
    hist_item_t it;
    int         pick;
    it = make_item(OP_PIXEL, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(255), $urandom_range(32767));
    pick = $urandom_range(99);
    if (pick < 68) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        it = palette[$urandom_range(5)];
      end else if (pick < 60) begin
        it.red   = 8'($urandom_range(251, 255));
        it.green = 8'($urandom_range(251, 255));
        it.blue  = 8'($urandom_range(251, 255));
      end
      it.operation = OP_PIXEL;
      it.alpha     = ($urandom_range(99) < 85) ? 8'($urandom_range(125, 255)) :
                                                 8'($urandom_range(124));
    end else if (pick < 94) begin
      it.operation = OP_READ;
      if (hit_bins.size() != 0 && $urandom_range(99) < 80)
        it.bin_index = 15'(hit_bins[$urandom_range(hit_bins.size() - 1)]);
    end else begin
      it.operation = OP_NONE;
    end
    return it;
  endfunction

  // One random phase: start from a clear, then random traffic
  task automatic run_random_phase(int n_items);
    for (int k = 0; k < 6; k++)
      palette[k] = make_item(OP_PIXEL, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), 255, 0);
    send_item(make_item(OP_CLEAR, $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(32767)));
    for (int n = 0; n < n_items; n++) send_item(random_item());
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 38;
    recv_idle_pct = 56;
    write_stride(1);
    run_random_phase(250);

    send_idle_pct = 56;
    recv_idle_pct = 38;
    write_stride($urandom_range(2, 9));
    run_random_phase(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_stride(255);
    run_random_phase(100);
    write_stride(1);
    for (int n = 0; n < 120; n++) send_item(random_item());
  endtask

  // Test sequence
  initial begin
    fail_count    = 0;
    send_idle_pct = 38;
    recv_idle_pct = 56;
    model_stride  = 8'd1;
    bin_counts.delete();
    reset_trackers();

    rst                     = 1'b1;
    item_if.valid           = 1'b0;
    item_if.operation       = OP_NONE;
    item_if.red             = '0;
    item_if.green           = '0;
    item_if.blue            = '0;
    item_if.alpha           = '0;
    item_if.bin_index       = '0;
    result_if.ready         = 1'b0;
    stride_if.valid         = 1'b0;
    stride_if.sample_stride = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_pixel_qualify();
    test_stride_zero();
    test_stride_lowered();
    test_clear();
    test_random_traffic();

    // Wait out the tail so any stray result gets scored
    drain_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/chb_pkg.sv
design/chb_if.sv
design/chb_ctrl.sv
design/chb_datapath.sv
design/color_histogram_builder_core.sv
tb/tb_color_histogram_builder_core.sv
